// File: hw/rtl/lmqu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmqu_pkg: shared types and constants for the urgent message queue
// Field widths, request and status codes, register indexes and the byte
// mask helper used by the queue core and the top level.
// ----------------------------------------------------------------------------
package lmqu_pkg;

    // Defaults for the top-level parameters
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MSG_BYTES_DEF   = 8;

    // Field widths
    localparam int PAYLOAD_W   = 64;
    localparam int LEN_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int TOTAL_W     = 32;
    localparam int MAXMSGS_W   = 5;
    localparam int MAXLEN_W    = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    // Register reset values
    localparam logic [MAXMSGS_W-1:0] MAX_MSGS_RST       = MAXMSGS_W'(16);
    localparam logic [MAXLEN_W-1:0]  MAX_MSG_LENGTH_RST = MAXLEN_W'(8);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSGS       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG_LENGTH = 1'b1;

    // Stream packing
    localparam int IN_FIELDS_W  = PAYLOAD_W + LEN_W + 1 + LEN_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = PAYLOAD_W + LEN_W + COUNT_W + 2 * TOTAL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        REQ_SEND = 1'b0,
        REQ_RECV = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef struct packed {
        t_req                 req_type;
        logic [PAYLOAD_W-1:0] payload_in;
        logic [LEN_W-1:0]     msg_length;
        logic                 urgent;
        logic [LEN_W-1:0]     max_bytes;
    } t_req_item;

    typedef struct packed {
        t_status              status;
        logic [PAYLOAD_W-1:0] payload_out;
        logic [LEN_W-1:0]     out_length;
        logic [COUNT_W-1:0]   msg_count;
        logic [TOTAL_W-1:0]   sent_total;
        logic [TOTAL_W-1:0]   received_total;
    } t_result;

    // Keep the low n bytes of a payload word
    function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [PAYLOAD_W-1:0] mask;
        mask = '0;
        for (int b = 0; b < PAYLOAD_W / 8; b++) begin
            mask[b*8 +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
        end
        return mask;
    endfunction

endpackage

// File: hw/rtl/linked_message_queue_urgent_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_message_queue_urgent_top: message queue with urgent front insertion
// Node slots on a free list and a used list; sends take a free slot, receives
// return the front message cut to the requested length.
//
//  Channel   Dir  Handshake                    Contents
//  s_axis    in   s_axis_tvalid/s_axis_tready  request transaction
//  m_axis    out  m_axis_tvalid/m_axis_tready  result transaction, one per request
//  cfg       in   i_cfg_we                     register write, no read-back
//
// One transaction per cycle sustained while m_axis_tready stays high; a request
// passes the input register, then the single-pass list update into the result register.
// The list heads read their RAMs at the next-state address, so each request
// finds its link and slot data ready in the cycle it is processed.
// Reset is synchronous and takes effect at once; there is no clearing pass.
// A stalled result holds the result register, and the input register then
// holds one more request before s_axis_tready drops.
// ----------------------------------------------------------------------------
module linked_message_queue_urgent_top #(
    parameter int QUEUE_DEPTH = lmqu_pkg::QUEUE_DEPTH_DEF,
    parameter int MSG_BYTES   = lmqu_pkg::MSG_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: payload_in[63:0], msg_length[67:64], urgent[68], max_bytes[72:69], zero pad
    input  logic [lmqu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[0]
    input  logic                             s_axis_tuser,
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: payload_out[63:0], out_length[67:64], msg_count[72:68],
    //        sent_total[104:73], received_total[136:105], zero pad
    output logic [lmqu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: status[1:0]
    output logic [lmqu_pkg::STATUS_W-1:0]    m_axis_tuser,
    // Configuration
    input  logic                             i_cfg_we,
    input  logic [lmqu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lmqu_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PW = lmqu_pkg::PAYLOAD_W;
    localparam int LW = lmqu_pkg::LEN_W;

    logic                           r_in_valid;
    lmqu_pkg::t_req_item            r_in_item;
    logic                           r_out_valid;
    lmqu_pkg::t_result              r_out;
    lmqu_pkg::t_result              core_result;
    logic                           proc_ready, fire, in_accept;
    logic [lmqu_pkg::MAXMSGS_W-1:0] r_max_msgs;
    logic [lmqu_pkg::MAXLEN_W-1:0]  r_max_msg_length;

    // Handshake
    assign proc_ready    = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && proc_ready;
    assign s_axis_tready = !r_in_valid || proc_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_msgs       <= lmqu_pkg::MAX_MSGS_RST;
            r_max_msg_length <= lmqu_pkg::MAX_MSG_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lmqu_pkg::CFG_MAX_MSGS: begin
                    r_max_msgs <= i_cfg_data[lmqu_pkg::MAXMSGS_W-1:0];
                end
                lmqu_pkg::CFG_MAX_MSG_LENGTH: begin
                    r_max_msg_length <= i_cfg_data[lmqu_pkg::MAXLEN_W-1:0];
                end
                default: begin
                    r_max_msgs <= r_max_msgs;
                end
            endcase
        end
    end

    // Input register: capture a transaction, drop it once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item.req_type   <= lmqu_pkg::t_req'(s_axis_tuser);
            r_in_item.payload_in <= s_axis_tdata[PW-1:0];
            r_in_item.msg_length <= s_axis_tdata[PW +: LW];
            r_in_item.urgent     <= s_axis_tdata[PW + LW];
            r_in_item.max_bytes  <= s_axis_tdata[PW + LW + 1 +: LW];
        end
    end

    // Queue core
    lmqu_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MSG_BYTES   (MSG_BYTES)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_item           (r_in_item),
        .i_max_msgs       (r_max_msgs),
        .i_max_msg_length (r_max_msg_length),
        .o_result         (core_result)
    );

    // Result register: load on processing, release when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {{(lmqu_pkg::OUT_TDATA_W - lmqu_pkg::OUT_FIELDS_W){1'b0}},
                            r_out.received_total,
                            r_out.sent_total,
                            r_out.msg_count,
                            r_out.out_length,
                            r_out.payload_out};

endmodule

// File: hw/rtl/lmqu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmqu_ram: generic simple dual-port RAM
// One write port and one read port, read data registered (read before write).
// ----------------------------------------------------------------------------
module lmqu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/lmqu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmqu_core: linked-list queue state and single-pass request update
// Holds list heads, counters and the slot, free-link and used-link RAMs.
// RAM reads are issued at the next-state heads so the data for the current
// heads is ready every cycle; same-cycle writes are forwarded.
// ----------------------------------------------------------------------------
module lmqu_core #(
    parameter int QUEUE_DEPTH = lmqu_pkg::QUEUE_DEPTH_DEF,
    parameter int MSG_BYTES   = lmqu_pkg::MSG_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  lmqu_pkg::t_req_item            i_item,
    input  logic [lmqu_pkg::MAXMSGS_W-1:0] i_max_msgs,
    input  logic [lmqu_pkg::MAXLEN_W-1:0]  i_max_msg_length,
    output lmqu_pkg::t_result              o_result
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W   = (CNT_W > lmqu_pkg::MAXMSGS_W) ? CNT_W : lmqu_pkg::MAXMSGS_W;
    localparam int PAY_W   = MSG_BYTES * 8;
    localparam int SLOT_W  = PAY_W + lmqu_pkg::LEN_W;
    localparam int LEN_W   = lmqu_pkg::LEN_W;

    // Queue state
    logic [IDX_W-1:0]             r_free_head, n_free_head;
    logic [CNT_W-1:0]             r_fresh, n_fresh;
    logic [IDX_W-1:0]             r_front, n_front;
    logic [IDX_W-1:0]             r_back, n_back;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [lmqu_pkg::TOTAL_W-1:0] r_sent, n_sent;
    logic [lmqu_pkg::TOTAL_W-1:0] r_recv, n_recv;

    // RAM write ports
    logic             slot_we, free_we, used_we;
    logic [IDX_W-1:0] slot_waddr, free_waddr, used_waddr;
    logic [SLOT_W-1:0] slot_wdata;
    logic [IDX_W-1:0] free_wdata, used_wdata;

    // RAM read data and forwarding
    logic [SLOT_W-1:0] slot_q, r_slot_fwd, slot_rd;
    logic [IDX_W-1:0]  free_q, r_free_fwd, free_next;
    logic [IDX_W-1:0]  used_q, r_used_fwd, used_next;
    logic              r_slot_fwd_v, r_free_fwd_v, r_used_fwd_v;

    // Request decode
    logic                          too_long, full, empty;
    logic [CAP_W-1:0]              cap;
    logic [LEN_W-1:0]              front_len, deliver_len;
    logic [lmqu_pkg::PAYLOAD_W-1:0] front_pay;
    lmqu_pkg::t_result             res;

    // Storage
    lmqu_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (n_front),
        .o_rdata (slot_q)
    );

    lmqu_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_DEPTH)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (free_waddr),
        .i_wdata (free_wdata),
        .i_raddr (n_free_head),
        .o_rdata (free_q)
    );

    lmqu_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_DEPTH)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_raddr (n_front),
        .o_rdata (used_q)
    );

    // Resolve read data for the current heads; never-taken slots link to i+1
    assign slot_rd   = r_slot_fwd_v ? r_slot_fwd : slot_q;
    assign used_next = r_used_fwd_v ? r_used_fwd : used_q;
    assign free_next = (CNT_W'(r_free_head) == r_fresh) ? (r_free_head + IDX_W'(1)) :
                       (r_free_fwd_v ? r_free_fwd : free_q);

    assign front_pay = lmqu_pkg::PAYLOAD_W'(slot_rd[PAY_W-1:0]);
    assign front_len = slot_rd[SLOT_W-1 -: LEN_W];

    // Status checks
    assign cap      = (CAP_W'(i_max_msgs) > CAP_W'(QUEUE_DEPTH)) ? CAP_W'(QUEUE_DEPTH)
                                                                : CAP_W'(i_max_msgs);
    assign too_long = (i_item.msg_length > i_max_msg_length) ||
                      (i_item.msg_length > LEN_W'(MSG_BYTES));
    assign full     = CAP_W'(r_count) >= cap;
    assign empty    = (r_count == '0);
    assign deliver_len = (i_item.max_bytes < front_len) ? i_item.max_bytes : front_len;

    // Single-pass update of the lists for one request
    always_comb begin
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_sent      = r_sent;
        n_recv      = r_recv;
        slot_we     = 1'b0;
        slot_waddr  = r_free_head;
        slot_wdata  = {i_item.msg_length,
                       PAY_W'(i_item.payload_in & lmqu_pkg::byte_mask(i_item.msg_length))};
        free_we     = 1'b0;
        free_waddr  = r_front;
        free_wdata  = r_free_head;
        used_we     = 1'b0;
        used_waddr  = r_back;
        used_wdata  = r_free_head;
        res.status      = lmqu_pkg::ST_OK;
        res.payload_out = '0;
        res.out_length  = '0;

        if (i_item.req_type == lmqu_pkg::REQ_SEND) begin
            if (too_long) begin
                res.status = lmqu_pkg::ST_TOO_LONG;
            end else if (full) begin
                res.status = lmqu_pkg::ST_FULL;
            end else if (i_fire) begin
                // Pop the free head and link it into the used list
                slot_we     = 1'b1;
                n_free_head = free_next;
                if (CNT_W'(r_free_head) == r_fresh) begin
                    n_fresh = r_fresh + CNT_W'(1);
                end
                if (empty) begin
                    n_front = r_free_head;
                    n_back  = r_free_head;
                end else if (!i_item.urgent) begin
                    used_we = 1'b1;
                    n_back  = r_free_head;
                end else begin
                    used_we    = 1'b1;
                    used_waddr = r_free_head;
                    used_wdata = r_front;
                    n_front    = r_free_head;
                end
                n_count = r_count + CNT_W'(1);
                n_sent  = r_sent + lmqu_pkg::TOTAL_W'(1);
            end
        end else begin
            if (empty) begin
                res.status = lmqu_pkg::ST_EMPTY;
            end else begin
                res.out_length  = deliver_len;
                res.payload_out = front_pay & lmqu_pkg::byte_mask(deliver_len);
                if (i_fire) begin
                    // Unlink the front slot and push it on the free list
                    free_we     = 1'b1;
                    n_front     = used_next;
                    n_free_head = r_front;
                    n_count     = r_count - CNT_W'(1);
                    n_recv      = r_recv + lmqu_pkg::TOTAL_W'(1);
                end
            end
        end

        res.msg_count      = lmqu_pkg::COUNT_W'(n_count);
        res.sent_total     = n_sent;
        res.received_total = n_recv;
    end

    assign o_result = res;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_fresh     <= '0;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_sent      <= '0;
            r_recv      <= '0;
        end else begin
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_front     <= n_front;
            r_back      <= n_back;
            r_count     <= n_count;
            r_sent      <= n_sent;
            r_recv      <= n_recv;
        end
    end

    // Forward a write that hits the address being read this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_fwd_v <= 1'b0;
            r_free_fwd_v <= 1'b0;
            r_used_fwd_v <= 1'b0;
        end else begin
            r_slot_fwd_v <= slot_we && (slot_waddr == n_front);
            r_free_fwd_v <= free_we && (free_waddr == n_free_head);
            r_used_fwd_v <= used_we && (used_waddr == n_front);
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot_fwd <= slot_wdata;
        r_free_fwd <= free_wdata;
        r_used_fwd <= used_wdata;
    end

    // Checks
    a_count_within_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_fresh)
        else $error("queued count exceeds slots ever taken");

    a_send_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.req_type == lmqu_pkg::REQ_SEND && res.status == lmqu_pkg::ST_OK
        |=> r_count == $past(r_count) + CNT_W'(1) &&
            r_sent == $past(r_sent) + lmqu_pkg::TOTAL_W'(1))
        else $error("send did not advance count and sent total");

    a_recv_frees_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.req_type == lmqu_pkg::REQ_RECV && res.status == lmqu_pkg::ST_OK
        |=> r_free_head == $past(r_front))
        else $error("received slot not returned to free list");

    a_fail_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.status != lmqu_pkg::ST_OK |=> $stable(r_count))
        else $error("failed request changed the queue count");

endmodule
